>>> rtl/layer_scale_factor_setup_macros.svh
// Assertion macros for the layer scale factor setup block.
`ifndef LAYER_SCALE_FACTOR_SETUP_MACROS_SVH
`define LAYER_SCALE_FACTOR_SETUP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LSFS_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LSFS_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSFS_ASSERT_CLK(label, clk, rst, prop, msg)
`define LSFS_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

>>> rtl/lsfs_pkg.sv
package lsfs_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int MAX_DIM_DEF   = 8192;
   localparam int SRC_W         = 29;
   localparam int DST_W         = 14;
   localparam int OFF_W         = 16;
   localparam logic [SRC_W-1:0] FACTOR_MAX = {SRC_W{1'b1}};

   // partial remainder / quotient carried along the divider chain
   typedef struct packed {
      logic [SRC_W-1:0] num_a;
      logic [DST_W-1:0] den_a;
      logic [SRC_W-1:0] rem_a;
      logic [SRC_W-1:0] quo_a;
      logic [SRC_W-1:0] num_b;
      logic [DST_W-1:0] den_b;
      logic [SRC_W-1:0] rem_b;
      logic [SRC_W-1:0] quo_b;
   } div_lane_type;
endpackage

>>> rtl/lsfs_div_cell.sv
// One restoring-division bit step for two independent quotients, registered.
module lsfs_div_cell #(
   parameter int BIT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 valid_in,
   input  lsfs_pkg::div_lane_type lane_in,
   output logic                 valid_out,
   output lsfs_pkg::div_lane_type lane_out
);
   localparam int W = lsfs_pkg::SRC_W;
   lsfs_pkg::div_lane_type lane_ff, lane_in_c;
   logic valid_ff;
   logic [W:0] ta, tb;

   always_comb begin
      lane_in_c = lane_in;
      ta = {lane_in.rem_a, lane_in.num_a[BIT]};
      if (ta >= {{(W+1-lsfs_pkg::DST_W){1'b0}}, lane_in.den_a}) begin
         ta = ta - {{(W+1-lsfs_pkg::DST_W){1'b0}}, lane_in.den_a};
         lane_in_c.quo_a[BIT] = 1'b1;
      end else begin
         lane_in_c.quo_a[BIT] = 1'b0;
      end
      lane_in_c.rem_a = ta[W-1:0];
      tb = {lane_in.rem_b, lane_in.num_b[BIT]};
      if (tb >= {{(W+1-lsfs_pkg::DST_W){1'b0}}, lane_in.den_b}) begin
         tb = tb - {{(W+1-lsfs_pkg::DST_W){1'b0}}, lane_in.den_b};
         lane_in_c.quo_b[BIT] = 1'b1;
      end else begin
         lane_in_c.quo_b[BIT] = 1'b0;
      end
      lane_in_c.rem_b = tb[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
      if (adv) begin
         lane_ff <= lane_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign lane_out  = lane_ff;
endmodule

>>> rtl/lsfs_div_chain.sv
// Row of bit cells, MSB first; den of zero yields all ones (saturated).
module lsfs_div_chain (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 valid_in,
   input  lsfs_pkg::div_lane_type lane_in,
   output logic                 valid_out,
   output lsfs_pkg::div_lane_type lane_out
);
   localparam int W = lsfs_pkg::SRC_W;
   logic                   v [W+1];
   lsfs_pkg::div_lane_type l [W+1];

   assign v[0] = valid_in;
   assign l[0] = lane_in;

   for (genvar i = 0; i < W; i++) begin : g_cell
      lsfs_div_cell #(.BIT(W-1-i)) u_cell (
         .clock(clock), .reset(reset), .adv(adv),
         .valid_in(v[i]), .lane_in(l[i]),
         .valid_out(v[i+1]), .lane_out(l[i+1])
      );
   end

   assign valid_out = v[W];
   assign lane_out  = l[W];
endmodule

>>> rtl/layer_scale_factor_setup.sv
// Channel | Ports                                        | Dir
// req     | req_valid req_stall req_src_* req_dst_* ...  | in
// rsp     | rsp_valid rsp_stall rsp_step_* rsp_phase_*   | out
//
// 2*29 + 1 register stages: the edge chain, the stretch chain, then the output
// register. One transaction per cycle sustained while rsp_stall does not hold the output.
// Two chains of 29 divider bit cells: edge-aligned then stretch quotients,
// both pairs computed for every transaction, selection at the end.
// The whole pipe advances when the output register is empty or being taken;
// req_stall is high only while the output register is held by rsp_stall.
// Synchronous active-high reset clears valid flags only.
`include "layer_scale_factor_setup_macros.svh"
module layer_scale_factor_setup #(
   parameter int FRAC_BITS = lsfs_pkg::FRAC_BITS_DEF,
   parameter int MAX_DIM   = lsfs_pkg::MAX_DIM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [28:0] req_src_width,
   input  logic [28:0] req_src_height,
   input  logic [13:0] req_dst_width,
   input  logic [13:0] req_dst_height,
   input  logic        req_quarter_turn,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [28:0] rsp_step_x,
   output logic [28:0] rsp_step_y,
   output logic [15:0] rsp_phase_x,
   output logic [15:0] rsp_phase_y,
   output logic        rsp_stretch,
   output logic        rsp_scale_enable
);
   localparam int W  = lsfs_pkg::SRC_W;
   localparam int DW = lsfs_pkg::DST_W;
   localparam logic [W-1:0] ONE  = W'(1) << FRAC_BITS;
   localparam logic [W-1:0] HALF = W'(1) << (FRAC_BITS-1);
   localparam logic [W-1:0] BIAS = W'(1) << (FRAC_BITS-6);
   // one bit wider than the size field so a limit of 2^DW never clamps
   localparam logic [DW:0] MAXD = (DW+1)'(MAX_DIM);

   logic adv;
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // input conditioning
   logic [W-1:0] sw, sh;
   logic [DW-1:0] dw, dh;
   lsfs_pkg::div_lane_type e_in, e_out, s_in, s_out;
   logic e_v, s_v;

   always_comb begin
      sw = req_quarter_turn ? req_src_height : req_src_width;
      sh = req_quarter_turn ? req_src_width  : req_src_height;
      dw = ({1'b0, req_dst_width}  > MAXD) ? MAXD[DW-1:0] : req_dst_width;
      dh = ({1'b0, req_dst_height} > MAXD) ? MAXD[DW-1:0] : req_dst_height;
      e_in = '0;
      e_in.num_a = (sw >= ONE) ? sw - ONE : '0;
      e_in.den_a = (dw != '0) ? dw - DW'(1) : '0;
      e_in.num_b = (sh >= ONE) ? sh - ONE : '0;
      e_in.den_b = (dh != '0) ? dh - DW'(1) : '0;
   end

   // side payload for the stretch operands (parallel delay line in cells' quo bits
   // is overwritten, so carry them in a separate pipe)
   logic [W-1:0]  sw_d [W];
   logic [W-1:0]  sh_d [W];
   logic [DW-1:0] dw_d [W];
   logic [DW-1:0] dh_d [W];
   always_ff @(posedge clock) begin
      if (adv) begin
         sw_d[0] <= sw; sh_d[0] <= sh; dw_d[0] <= dw; dh_d[0] <= dh;
         for (int i = 1; i < W; i++) begin
            sw_d[i] <= sw_d[i-1]; sh_d[i] <= sh_d[i-1];
            dw_d[i] <= dw_d[i-1]; dh_d[i] <= dh_d[i-1];
         end
      end
   end

   lsfs_div_chain u_edge (
      .clock(clock), .reset(reset), .adv(adv),
      .valid_in(req_valid), .lane_in(e_in),
      .valid_out(e_v), .lane_out(e_out)
   );

   logic [W-1:0] efx, efy;
   assign efx = (e_out.den_a == '0) ? lsfs_pkg::FACTOR_MAX : e_out.quo_a;
   assign efy = (e_out.den_b == '0) ? lsfs_pkg::FACTOR_MAX : e_out.quo_b;

   always_comb begin
      s_in = '0;
      s_in.num_a = sw_d[W-1];
      s_in.den_a = dw_d[W-1];
      s_in.num_b = sh_d[W-1];
      s_in.den_b = dh_d[W-1];
      // carry edge factors in the remainder-free slots is not possible; use pipe
   end

   logic [W-1:0] efx_d [W];
   logic [W-1:0] efy_d [W];
   always_ff @(posedge clock) begin
      if (adv) begin
         efx_d[0] <= efx; efy_d[0] <= efy;
         for (int i = 1; i < W; i++) begin
            efx_d[i] <= efx_d[i-1]; efy_d[i] <= efy_d[i-1];
         end
      end
   end

   lsfs_div_chain u_stretch (
      .clock(clock), .reset(reset), .adv(adv),
      .valid_in(e_v), .lane_in(s_in),
      .valid_out(s_v), .lane_out(s_out)
   );

   // final selection
   localparam int OFF_W_L = lsfs_pkg::OFF_W;
   logic [W-1:0] fx, fy, sfx, sfy, ex, ey;
   logic [OFF_W_L-1:0] ox, oy;
   logic stretch;
   always_comb begin
      ex = efx_d[W-1];
      ey = efy_d[W-1];
      sfx = (s_out.den_a == '0) ? lsfs_pkg::FACTOR_MAX : s_out.quo_a;
      sfy = (s_out.den_b == '0) ? lsfs_pkg::FACTOR_MAX : s_out.quo_b;
      stretch = (ex != ey);
      fx = stretch ? sfx : ex;
      fy = stretch ? sfy : ey;
      if (stretch) begin
         ox = (fx < ONE) ? OFF_W_L'((fx >> 1) + BIAS) : '0;
         oy = (fy < ONE) ? OFF_W_L'((fy >> 1) + BIAS) : '0;
      end else begin
         ox = (fx < ONE) ? OFF_W_L'(HALF) : '0;
         oy = (fy < ONE) ? OFF_W_L'(HALF) : '0;
      end
   end

   logic valid_ff;
   logic [W-1:0] fx_ff, fy_ff;
   logic [OFF_W_L-1:0] ox_ff, oy_ff;
   logic st_ff, en_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= s_v;
      end
      if (adv) begin
         fx_ff <= fx; fy_ff <= fy; ox_ff <= ox; oy_ff <= oy;
         st_ff <= stretch;
         en_ff <= (fx != ONE) || (fy != ONE);
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_step_x       = fx_ff;
   assign rsp_step_y       = fy_ff;
   assign rsp_phase_x      = ox_ff;
   assign rsp_phase_y      = oy_ff;
   assign rsp_stretch      = st_ff;
   assign rsp_scale_enable = en_ff;

   `LSFS_ASSERT_CLK(a_stall_hold, clock, reset, $past(rsp_valid && rsp_stall) |-> $stable(rsp_step_x) && $stable(rsp_phase_x), "held result changed")
   `LSFS_ASSERT_CLK(a_stall_link, clock, reset, req_stall |-> rsp_valid && rsp_stall, "input stalled without output stall")
   `LSFS_ASSERT_CLK(a_offset_zero, clock, reset, rsp_valid && rsp_step_x >= ONE |-> rsp_phase_x == '0, "offset on non-upscaled axis")
   `LSFS_ASSERT_NORST(a_reset_clear, clock, reset |=> !rsp_valid, "valid after reset")
endmodule
